### design/prtw_pkg.sv
package prtw_pkg;

  localparam int PAGE_BYTES = 4096;
  localparam int PAGE_BITS  = 12;
  localparam int L1_SHIFT   = 20;

  // Depth of the request queue between the front and the back.
  localparam int FQ_DEPTH = 2;

  // Result queue: the back pushes up to two results a cycle.
  localparam int OQ_DEPTH = 4;
  localparam int OQ_PW    = $clog2(OQ_DEPTH);
  localparam int OQ_CW    = $clog2(OQ_DEPTH + 1);

  localparam logic FUNC_START = 1'b0;
  localparam logic FUNC_DESC  = 1'b1;

  localparam logic [1:0] KIND_READ  = 2'd0;
  localparam logic [1:0] KIND_MAINT = 2'd1;
  localparam logic [1:0] KIND_DONE  = 2'd2;

  // Level-1 descriptor type code for a pointer to a level-2 table.
  localparam logic [1:0] L1_TYPE_TABLE = 2'b01;

  localparam logic [1:0] ADDR_TABLE_BASE = 2'd0;

  typedef struct packed {
    logic        is_start;
    logic [31:0] start_addr;
    logic [32:0] remaining;
    logic [12:0] first_chunk;
    logic        op;
    logic [31:0] descriptor;
  } entry_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] address;
    logic [12:0] chunk_length;
    logic        operation;
    logic        last;
  } result_t;

  typedef struct packed {
    logic [1:0] n;
    result_t    r0;
    result_t    r1;
  } push_t;

endpackage

### design/prtw_front.sv
module prtw_front #(
  parameter int DEPTH = prtw_pkg::FQ_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic             func,
  input  logic [31:0]      start_addr,
  input  logic [31:0]      byte_count,
  input  logic             cache_op,
  input  logic [31:0]      descriptor,
  output logic             head_valid,
  output prtw_pkg::entry_t head,
  input  logic             take
);
  import prtw_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [32:0] ADDR_SPACE = 33'h1_0000_0000;

  entry_t         mem [DEPTH];
  logic [PW-1:0]  wptr;
  logic [PW-1:0]  rptr;
  logic [CW-1:0]  count;
  entry_t         incoming;
  logic [32:0]    limit;
  logic [32:0]    remaining;
  logic [12:0]    page_left;
  logic           push;

  // The range length is clipped so that the range stops at the top of the address space.
  always_comb begin
    limit     = ADDR_SPACE - {1'b0, start_addr};
    remaining = ({1'b0, byte_count} > limit) ? limit : {1'b0, byte_count};
    page_left = 13'(PAGE_BYTES) - {1'b0, start_addr[PAGE_BITS-1:0]};
    incoming.is_start    = (func == FUNC_START);
    incoming.start_addr  = start_addr;
    incoming.remaining   = remaining;
    incoming.first_chunk = (remaining < 33'(page_left)) ? remaining[12:0] : page_left;
    incoming.op          = cache_op;
    incoming.descriptor  = descriptor;
  end

  assign in_stall   = (count == CW'(DEPTH));
  assign push       = in_valid && !in_stall;
  assign head_valid = (count != '0);
  assign head       = mem[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= incoming;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == PW'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (take) begin
        rptr <= (rptr == PW'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      count <= count + CW'(push) - CW'(take);
    end
  end

endmodule

### design/prtw_back.sv
module prtw_back (
  input  logic             clk,
  input  logic             rst,
  input  logic [31:0]      table_base,
  input  logic             head_valid,
  input  prtw_pkg::entry_t head,
  output logic             take,
  input  logic             ready,
  output prtw_pkg::push_t  push
);
  import prtw_pkg::*;

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_L1   = 2'd1;
  localparam logic [1:0] PH_L2   = 2'd2;

  logic [1:0]  phase, phase_next;
  logic [31:0] cursor, cursor_next;
  logic [32:0] cur_after, cur_after_next;
  logic [32:0] rem_after, rem_after_next;
  logic [12:0] chunk, chunk_next;
  logic        held_op, held_op_next;

  logic [12:0] adv_chunk;
  logic [31:0] adv_read;
  logic [31:0] start_read;
  logic [31:0] l2_read;
  logic [31:0] paddr;
  result_t     adv_res;

  function automatic result_t mk(logic [1:0] k, logic [31:0] a, logic [12:0] len,
                                 logic op, logic lst);
    result_t r;
    r.kind         = k;
    r.address      = a;
    r.chunk_length = len;
    r.operation    = op;
    r.last         = lst;
    return r;
  endfunction

  assign take = head_valid && ready;

  always_comb begin
    adv_chunk  = (rem_after >= 33'(PAGE_BYTES)) ? 13'(PAGE_BYTES) : rem_after[12:0];
    adv_read   = table_base + {18'b0, cur_after[31:L1_SHIFT], 2'b00};
    start_read = table_base + {18'b0, head.start_addr[31:L1_SHIFT], 2'b00};
    l2_read    = {head.descriptor[31:10], 10'b0} + {22'b0, cursor[19:PAGE_BITS], 2'b00};
    paddr      = {head.descriptor[31:PAGE_BITS], cursor[PAGE_BITS-1:0]};
    if (rem_after == '0) begin
      adv_res = mk(KIND_DONE, 32'd0, 13'd0, held_op, 1'b1);
    end else begin
      adv_res = mk(KIND_READ, adv_read, 13'd0, held_op, 1'b0);
    end
  end

  always_comb begin
    phase_next     = phase;
    cursor_next    = cursor;
    cur_after_next = cur_after;
    rem_after_next = rem_after;
    chunk_next     = chunk;
    held_op_next   = held_op;
    push           = '0;
    if (take) begin
      if (head.is_start) begin
        held_op_next = head.op;
        push.n       = 2'd1;
        if (head.remaining == '0) begin
          phase_next = PH_IDLE;
          push.r0    = mk(KIND_DONE, 32'd0, 13'd0, head.op, 1'b1);
        end else begin
          phase_next     = PH_L1;
          cursor_next    = head.start_addr;
          chunk_next     = head.first_chunk;
          rem_after_next = head.remaining - 33'(head.first_chunk);
          cur_after_next = {1'b0, head.start_addr} + 33'(head.first_chunk);
          push.r0        = mk(KIND_READ, start_read, 13'd0, head.op, 1'b0);
        end
      end else begin
        case (phase)
          PH_L1, PH_L2: begin
            if (phase == PH_L1 && head.descriptor[1:0] == L1_TYPE_TABLE) begin
              phase_next = PH_L2;
              push.n     = 2'd1;
              push.r0    = mk(KIND_READ, l2_read, 13'd0, held_op, 1'b0);
            end else begin
              // Next page or done; a maintenance command first if mapped, paddr != 0.
              if (phase == PH_L2 && head.descriptor[1] && paddr != '0) begin
                push.n  = 2'd2;
                push.r0 = mk(KIND_MAINT, paddr, chunk, held_op, 1'b0);
                push.r1 = adv_res;
              end else begin
                push.n  = 2'd1;
                push.r0 = adv_res;
              end
              if (rem_after == '0) begin
                phase_next = PH_IDLE;
              end else begin
                phase_next     = PH_L1;
                cursor_next    = cur_after[31:0];
                chunk_next     = adv_chunk;
                rem_after_next = rem_after - 33'(adv_chunk);
                cur_after_next = cur_after + 33'(adv_chunk);
              end
            end
          end
          default: begin
            push.n = 2'd0;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_IDLE;
      cursor    <= '0;
      cur_after <= '0;
      rem_after <= '0;
      chunk     <= '0;
      held_op   <= 1'b0;
    end else begin
      phase     <= phase_next;
      cursor    <= cursor_next;
      cur_after <= cur_after_next;
      rem_after <= rem_after_next;
      chunk     <= chunk_next;
      held_op   <= held_op_next;
    end
  end

  a_pair_starts_with_maint: assert property (@(posedge clk) disable iff (rst)
    push.n == 2'd2 |-> push.r0.kind == KIND_MAINT)
    else $error("two results in one step without a maintenance command first");

  a_start_one_result: assert property (@(posedge clk) disable iff (rst)
    (take && head.is_start) |-> push.n == 2'd1)
    else $error("start beat did not give exactly one result");

  a_done_goes_idle: assert property (@(posedge clk) disable iff (rst)
    (push.n == 2'd1 && push.r0.kind == KIND_DONE) |=> phase == PH_IDLE)
    else $error("walker not idle after done");

endmodule

### design/prtw_out_q.sv
module prtw_out_q (
  input  logic              clk,
  input  logic              rst,
  input  prtw_pkg::push_t   push,
  output logic              ready,
  output logic              valid,
  input  logic              stall,
  output prtw_pkg::result_t head
);
  import prtw_pkg::*;

  result_t          mem [OQ_DEPTH];
  logic [OQ_PW-1:0] wptr;
  logic [OQ_PW-1:0] rptr;
  logic [OQ_CW-1:0] count;
  logic             pop;

  assign valid = (count != '0);
  assign pop   = valid && !stall;
  assign head  = mem[rptr];
  // Room for the largest push of one step.
  assign ready = (count <= OQ_CW'(OQ_DEPTH - 2));

  always_ff @(posedge clk) begin
    if (push.n != 2'd0) begin
      mem[wptr] <= push.r0;
    end
    if (push.n == 2'd2) begin
      mem[wptr + 1'b1] <= push.r1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      wptr  <= wptr + OQ_PW'(push.n);
      rptr  <= rptr + OQ_PW'(pop);
      count <= count + OQ_CW'(push.n) - OQ_CW'(pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count <= OQ_CW'(OQ_DEPTH))
    else $error("result queue overflow");

  a_push_needs_room: assert property (@(posedge clk) disable iff (rst)
    push.n != 2'd0 |-> ready)
    else $error("push into result queue without room");

  a_first_result_shows: assert property (@(posedge clk) disable iff (rst)
    (!valid && push.n != 2'd0) |=> (valid && head == $past(push.r0)))
    else $error("result pushed into empty queue not at head");

endmodule

### design/page_range_translate_walker.sv
// Range cache-maintenance walker over a two-level short-descriptor page table.
// Input channel (in_valid / in_stall): a beat with func = 0 starts a range given by
// start_addr, byte_count and cache_op; a beat with func = 1 returns the descriptor word
// asked for by the last read request. A start abandons any walk in progress.
// Output channel (out_valid / out_stall): each beat is a descriptor read request, a
// maintenance command over one physical chunk of at most one page, or the done beat
// with last set. A beat causes zero, one or two results.
// table_base is written through the APB-style port; the user must write it only while
// the block is idle, which the block itself does not enforce. A beat is registered in
// the request queue, and its results are registered in the result queue; the walker
// step between them is combinational. The request queue takes one input beat a cycle
// while not full, and the result queue drains one beat a cycle while out_stall is low.
// When the receiver stalls, results pile up in the four-entry result queue; the
// walker waits once fewer than two entries are free, and in_stall rises when the
// request queue fills. Reset empties both queues, idles the walker and clears
// table_base; no clearing pass is needed.
module page_range_translate_walker #(
  parameter int FRONT_DEPTH = prtw_pkg::FQ_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        func,
  input  logic [31:0] start_addr,
  input  logic [31:0] byte_count,
  input  logic        cache_op,
  input  logic [31:0] descriptor,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  kind,
  output logic [31:0] address,
  output logic [12:0] chunk_length,
  output logic        operation,
  output logic        last,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import prtw_pkg::*;

  logic [31:0] table_base;
  logic        head_valid;
  entry_t      head;
  logic        take;
  logic        ready;
  push_t       push;
  result_t     result;

  // Register port: a single register at byte address zero.
  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_TABLE_BASE) ? table_base : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      table_base <= '0;
    end else if (psel && penable && pwrite && pready && paddr == ADDR_TABLE_BASE) begin
      table_base <= pwdata;
    end
  end

  // The front clips the range and works out the first chunk before queueing the beat.
  prtw_front #(
    .DEPTH(FRONT_DEPTH)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .func       (func),
    .start_addr (start_addr),
    .byte_count (byte_count),
    .cache_op   (cache_op),
    .descriptor (descriptor),
    .head_valid (head_valid),
    .head       (head),
    .take       (take)
  );

  // The back holds the walk state and turns each queued beat into its results.
  prtw_back u_back (
    .clk        (clk),
    .rst        (rst),
    .table_base (table_base),
    .head_valid (head_valid),
    .head       (head),
    .take       (take),
    .ready      (ready),
    .push       (push)
  );

  prtw_out_q u_out_q (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .ready (ready),
    .valid (out_valid),
    .stall (out_stall),
    .head  (result)
  );

  assign kind         = result.kind;
  assign address      = result.address;
  assign chunk_length = result.chunk_length;
  assign operation    = result.operation;
  assign last         = result.last;

endmodule

### test/page_range_translate_walker_tb.sv
module page_range_translate_walker_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import prtw_pkg::*;

  // Clean or flush, as carried by cache_op and echoed on operation.
  localparam logic OP_CLEAN = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  // Results pass through the request and result queues after the causing beat; the
  // DRAIN_CYCLES wait covers both queues before we touch the register.
  localparam int DRAIN_CYCLES   = 8;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int RANDOM_PHASES  = 5;
  localparam int PHASE_BEATS    = 100;

  // One beat on the input channel.
  typedef struct packed {
    logic        func;
    logic [31:0] start_addr;
    logic [31:0] byte_count;
    logic        cache_op;
    logic [31:0] descriptor;
  } beat_t;

  typedef enum logic [1:0] {WALK_IDLE, WALK_L1, WALK_L2} walk_phase_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        func = FUNC_START;
  logic [31:0] start_addr = '0;
  logic [31:0] byte_count = '0;
  logic        cache_op = OP_CLEAN;
  logic [31:0] descriptor = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  kind;
  logic [31:0] address;
  logic [12:0] chunk_length;
  logic        operation;
  logic        last;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [1:0]  paddr = ADDR_TABLE_BASE;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // When set, neither side idles: this gives a stretch at full throughput.
  logic steady = 1'b0;
  int   fail_count = 0;
  int   idle_cycles = 0;

  // Walk state as the block should hold it, plus the register copy.
  walk_phase_t walk_phase = WALK_IDLE;
  logic [32:0] walk_cursor = '0;
  logic [32:0] walk_end = '0;
  logic        walk_op = OP_CLEAN;
  logic [12:0] walk_chunk = '0;
  logic [31:0] table_base_model = '0;

  // Results the block still owes, oldest first.
  result_t pending_results[$];

  page_range_translate_walker i_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .func         (func),
    .start_addr   (start_addr),
    .byte_count   (byte_count),
    .cache_op     (cache_op),
    .descriptor   (descriptor),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .kind         (kind),
    .address      (address),
    .chunk_length (chunk_length),
    .operation    (operation),
    .last         (last),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic void note_failure(string msg);
    fail_count++;
    if (fail_count <= 10) begin
      $display("mismatch at %0t: %s", $realtime, msg);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Walk predictor. Every result carries the held clean/flush code.
  // ---------------------------------------------------------------------------
  function automatic void owe_result(logic [1:0] k, logic [31:0] a, logic [12:0] len,
                                     logic lst);
    result_t r;
    r.kind         = k;
    r.address      = a;
    r.chunk_length = len;
    r.operation    = walk_op;
    r.last         = lst;
    pending_results.push_back(r);
  endfunction

  // Ask for the level-1 word of the page under the cursor, or finish the range.
  // The chunk runs to the next page boundary or to the range end, whichever
  // comes first.
  function automatic void open_next_page();
    logic [32:0] page_limit;
    logic [32:0] span;
    if (walk_cursor >= walk_end) begin
      walk_phase = WALK_IDLE;
      walk_chunk = '0;
      owe_result(KIND_DONE, '0, '0, 1'b1);
    end else begin
      page_limit = {walk_cursor[32:PAGE_BITS] + 21'd1, {PAGE_BITS{1'b0}}};
      if (page_limit > walk_end) begin
        page_limit = walk_end;
      end
      span       = page_limit - walk_cursor;
      walk_chunk = span[12:0];
      walk_phase = WALK_L1;
      owe_result(KIND_READ, table_base_model + {18'b0, walk_cursor[31:L1_SHIFT], 2'b00},
                 '0, 1'b0);
    end
  endfunction

  function automatic void advance_page();
    walk_cursor = walk_cursor + {20'b0, walk_chunk};
    open_next_page();
  endfunction

  // Apply one accepted beat to the walk state and queue what it causes.
  function automatic void walk_step(beat_t b);
    logic [32:0] range_end;
    logic [31:0] phys;
    if (b.func == FUNC_START) begin
      // The range end saturates at 2^32 rather than wrapping.
      range_end = {1'b0, b.start_addr} + {1'b0, b.byte_count};
      if (range_end > 33'h1_0000_0000) begin
        range_end = 33'h1_0000_0000;
      end
      walk_cursor = {1'b0, b.start_addr};
      walk_end    = range_end;
      walk_op     = b.cache_op;
      open_next_page();
    end else if (walk_phase == WALK_L1) begin
      if (b.descriptor[1:0] != L1_TYPE_TABLE) begin
        advance_page();
      end else begin
        walk_phase = WALK_L2;
        owe_result(KIND_READ,
                   {b.descriptor[31:10], 10'b0} + {22'b0, walk_cursor[19:PAGE_BITS], 2'b00},
                   '0, 1'b0);
      end
    end else if (walk_phase == WALK_L2) begin
      if (!b.descriptor[1]) begin
        advance_page();
      end else begin
        // A translation to physical address zero is dropped without a command.
        phys = {b.descriptor[31:PAGE_BITS], walk_cursor[PAGE_BITS-1:0]};
        if (phys != '0) begin
          owe_result(KIND_MAINT, phys, walk_chunk, 1'b0);
        end
        advance_page();
      end
    end
    // A descriptor beat while idle is dropped by the block.
  endfunction

  // ---------------------------------------------------------------------------
  // Beat construction. Fields the block does not use for a given func still
  // get random values so every input bit toggles.
  // ---------------------------------------------------------------------------
  function automatic beat_t start_beat(logic [31:0] a, logic [31:0] n, logic op);
    beat_t b;
    b.func       = FUNC_START;
    b.start_addr = a;
    b.byte_count = n;
    b.cache_op   = op;
    b.descriptor = $urandom;
    return b;
  endfunction

  function automatic beat_t descriptor_beat(logic [31:0] d);
    beat_t b;
    b.func       = FUNC_DESC;
    b.start_addr = $urandom;
    b.byte_count = $urandom;
    b.cache_op   = 1'($urandom_range(0, 1));
    b.descriptor = d;
    return b;
  endfunction

  // Drive one beat and hold it until accepted. in_valid is lowered only for
  // idle cycles, so back-to-back beats never see two assignments in one step.
  task automatic send_beat(beat_t b);
    while (!steady && $urandom_range(0, 99) < 14) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    func       <= b.func;
    start_addr <= b.start_addr;
    byte_count <= b.byte_count;
    cache_op   <= b.cache_op;
    descriptor <= b.descriptor;
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
    walk_step(b);
  endtask

  // Stop sending and wait until the block has delivered everything it owes.
  // A descriptor beat may cause nothing, so a few more cycles let it retire.
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Write table_base over the APB port, then read it back.
  task automatic set_table_base(logic [31:0] value);
    drain();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_TABLE_BASE;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) begin
      @(posedge clk);
    end
    table_base_model = value;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) begin
      @(posedge clk);
    end
    if (prdata !== value) begin
      note_failure($sformatf("table_base read back %h, wrote %h", prdata, value));
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Directed tests, run with table_base at its reset value unless noted.
  // ---------------------------------------------------------------------------

  // A short range inside one page: level-1, level-2, one command, done.
  task automatic test_single_page();
    send_beat(start_beat(32'h1234_5678, 32'h0000_0100, OP_FLUSH));
    send_beat(descriptor_beat(32'h0000_4C01));
    send_beat(descriptor_beat(32'h8765_4002));
  endtask

  // Zero length finishes at once.
  task automatic test_empty_range();
    send_beat(start_beat(32'h0000_1000, 32'h0000_0000, OP_CLEAN));
  endtask

  // A range that straddles a boundary: a 16-byte head, then a full page.
  task automatic test_page_split();
    send_beat(start_beat(32'h0000_0FF0, 32'h0000_1010, OP_CLEAN));
    send_beat(descriptor_beat(32'h0000_0C01));
    send_beat(descriptor_beat(32'h0010_0002));
    send_beat(descriptor_beat(32'hFFFF_FC01));
    send_beat(descriptor_beat(32'hFFFF_F003));
  endtask

  // Level-1 words of the wrong type, then a level-2 word without bit 1:
  // each page is skipped with no command.
  task automatic test_invalid_pages();
    send_beat(start_beat(32'h0030_0000, 32'h0000_3000, OP_CLEAN));
    send_beat(descriptor_beat(32'h0000_0000));
    send_beat(descriptor_beat(32'hFFFF_FFFF));
    send_beat(descriptor_beat(32'hFFFF_FFFD));
    send_beat(descriptor_beat(32'hFFFF_FFFD));
  endtask

  // A valid page that translates to physical zero gives no command.
  task automatic test_zero_translation();
    send_beat(start_beat(32'h0040_0000, 32'h0000_1000, OP_FLUSH));
    send_beat(descriptor_beat(32'h0000_8001));
    send_beat(descriptor_beat(32'h0000_0002));
  endtask

  // The top page with an all-ones length: the end saturates at 2^32 and the
  // level-1 address wraps past the all-ones table base.
  task automatic test_saturated_end();
    set_table_base(32'hFFFF_FFFF);
    send_beat(start_beat(32'hFFFF_F800, 32'hFFFF_FFFF, OP_FLUSH));
    send_beat(descriptor_beat(32'h0000_0001));
    send_beat(descriptor_beat(32'hFFFF_FFFF));
  endtask

  // A start in the middle of a walk abandons it and walks the new range.
  task automatic test_restart_while_busy();
    set_table_base(32'h0000_0000);
    send_beat(start_beat(32'h0000_0000, 32'hFFFF_FFFF, OP_CLEAN));
    send_beat(descriptor_beat(32'h0000_0401));
    send_beat(start_beat(32'h7FFF_F000, 32'h0000_0001, OP_FLUSH));
    send_beat(descriptor_beat(32'h0000_0001));
    send_beat(descriptor_beat(32'h0000_1002));
  endtask

  // A descriptor with no walk in progress is dropped.
  task automatic test_idle_descriptor();
    send_beat(descriptor_beat(32'hA5A5_A5A5));
  endtask

  // ---------------------------------------------------------------------------
  // Random walks. Most beats answer the walk with well-formed words of random
  // content; some are noise, and walks are often cut short by a new start.
  // ---------------------------------------------------------------------------
  function automatic beat_t random_start();
    int          pick;
    logic [31:0] a;
    logic [31:0] n;
    pick = $urandom_range(0, 99);
    a    = $urandom;
    if (pick < 60) begin
      n = $urandom_range(0, 3 * PAGE_BYTES);
    end else if (pick < 75) begin
      n = $urandom;
    end else if (pick < 90) begin
      // Near the top of the address space, usually saturating.
      a = {16'hFFFF, a[15:0]};
      n = $urandom;
    end else begin
      n = $urandom_range(1, 16);
    end
    return start_beat(a, n, 1'($urandom_range(0, 1)));
  endfunction

  function automatic beat_t random_answer();
    logic [31:0] d;
    d = $urandom;
    if ($urandom_range(0, 99) >= 8) begin
      if (walk_phase == WALK_L1) begin
        d[1:0] = L1_TYPE_TABLE;
      end else begin
        d[1] = 1'b1;
        if ($urandom_range(0, 99) < 3) begin
          d[31:PAGE_BITS] = '0;
        end
      end
    end
    return descriptor_beat(d);
  endfunction

  task automatic random_phase(int beats);
    int counted;
    int answered;
    int cap;
    counted = 0;
    while (counted < beats) begin
      send_beat(random_start());
      counted++;
      answered = 0;
      cap      = $urandom_range(2, 14);
      while (walk_phase != WALK_IDLE && answered < cap && counted < beats) begin
        send_beat(random_answer());
        answered++;
        counted++;
      end
      // Stray word after the walk; the block drops it, so it is not counted.
      if (walk_phase == WALK_IDLE && $urandom_range(0, 99) < 10) begin
        send_beat(descriptor_beat($urandom));
      end
    end
  endtask

  // Several table bases, the extremes among them; the middle phase runs
  // with no idling on either side.
  task automatic test_random_walks();
    logic [31:0] base;
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        1: begin
          base = 32'hFFFF_C000;
        end
        2: begin
          base = $urandom;
        end
        3: begin
          base = 32'h0000_0000;
        end
        default: begin
          base = {18'($urandom_range(0, 32'h3FFFF)), 14'b0};
        end
      endcase
      set_table_base(base);
      steady = (p == 2);
      random_phase(PHASE_BEATS);
    end
    steady = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Output side: random stall, and the check of every result beat against the
  // oldest owed result.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    out_stall <= !steady && ($urandom_range(0, 99) < 14);
  end

  always @(posedge clk) begin : check_results
    result_t got;
    result_t want;
    if (!rst && out_valid && !out_stall) begin
      got.kind         = kind;
      got.address      = address;
      got.chunk_length = chunk_length;
      got.operation    = operation;
      got.last         = last;
      if (pending_results.size() == 0) begin
        note_failure($sformatf("unowed result kind=%0d addr=%h len=%0d op=%0d last=%0d",
                               got.kind, got.address, got.chunk_length, got.operation,
                               got.last));
      end else begin
        want = pending_results.pop_front();
        if (got.kind !== want.kind || got.address !== want.address ||
            got.chunk_length !== want.chunk_length || got.operation !== want.operation ||
            got.last !== want.last) begin
          note_failure($sformatf({"expected kind=%0d addr=%h len=%0d op=%0d last=%0d, ",
                                  "got kind=%0d addr=%h len=%0d op=%0d last=%0d"},
                                 want.kind, want.address, want.chunk_length,
                                 want.operation, want.last, got.kind, got.address,
                                 got.chunk_length, got.operation, got.last));
        end
      end
    end
  end

  // Watchdog: ends a run in which no beat moves on either channel for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_single_page();
    test_empty_range();
    test_page_split();
    test_invalid_pages();
    test_zero_translation();
    test_saturated_end();
    test_restart_while_busy();
    test_idle_descriptor();
    test_random_walks();

    drain();
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
